### rtl/mcps_pkg.sv
`timescale 1ns / 1ps

package mcps_pkg;

    // Matrix geometry.
    localparam int MAX_N   = 8;
    localparam int IDX_W   = $clog2(MAX_N);
    localparam int DEPTH   = MAX_N * MAX_N;
    localparam int ADDR_W  = $clog2(DEPTH);

    // Field widths.
    localparam int SIZE_W  = 4;
    localparam int COST_W  = 24;
    localparam int SUM_W   = 32;
    localparam int ROW_W   = 3;
    localparam int DATA_W  = 32;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_BOUND = 1'd1;
    localparam logic [SIZE_W-1:0]    SIZE_RESET      = 4'd8;
    localparam logic [SUM_W-1:0]     BOUND_RESET     = 32'd256000;

    // One permutation of the column indexes, position 0 is row 0.
    typedef logic [MAX_N-1:0][IDX_W-1:0] perm_t;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              last_entry;
    } in_item_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] column;
        logic [SUM_W-1:0] best_sum;
        logic             found;
        logic             last_result;
    } out_item_t;

endpackage

### rtl/mcps_ram.sv
`timescale 1ns / 1ps

module mcps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/mcps_perm_next.sv
`timescale 1ns / 1ps

module mcps_perm_next (
    input  mcps_pkg::perm_t                  perm,
    input  logic [mcps_pkg::SIZE_W-1:0]      n,
    output mcps_pkg::perm_t                  perm_next,
    output logic                             has_next
);

    logic [mcps_pkg::IDX_W-1:0]  pivot;
    logic [mcps_pkg::IDX_W-1:0]  swap_idx;
    logic [mcps_pkg::IDX_W-1:0]  src_idx;
    logic [mcps_pkg::SIZE_W:0]   src_full;

    // The pivot is the last position whose value is below its right neighbor.
    always_comb
    begin
        pivot    = '0;
        has_next = 1'b0;
        for (int k = 0; k < mcps_pkg::MAX_N - 1; k++)
        begin
            if ((mcps_pkg::SIZE_W'(k + 1) < n) && (perm[k] < perm[k + 1]))
            begin
                pivot    = mcps_pkg::IDX_W'(k);
                has_next = 1'b1;
            end
        end
    end

    // The swap partner is the last position after the pivot with a larger value.
    always_comb
    begin
        swap_idx = '0;
        for (int m = 0; m < mcps_pkg::MAX_N; m++)
        begin
            if ((mcps_pkg::SIZE_W'(m) < n) && (mcps_pkg::IDX_W'(m) > pivot)
                && (perm[m] > perm[pivot]))
            begin
                swap_idx = mcps_pkg::IDX_W'(m);
            end
        end
    end

    // Swap the pivot with its partner, then reverse the suffix behind the pivot.
    always_comb
    begin
        src_full = '0;
        src_idx  = '0;
        for (int m = 0; m < mcps_pkg::MAX_N; m++)
        begin
            if (mcps_pkg::IDX_W'(m) < pivot)
            begin
                perm_next[m] = perm[m];
            end
            else if (mcps_pkg::IDX_W'(m) == pivot)
            begin
                perm_next[m] = perm[swap_idx];
            end
            else if (mcps_pkg::SIZE_W'(m) < n)
            begin
                src_full = {1'b0, n} + (mcps_pkg::SIZE_W + 1)'(pivot)
                           - (mcps_pkg::SIZE_W + 1)'(m);
                src_idx  = src_full[mcps_pkg::IDX_W-1:0];
                perm_next[m] = (src_idx == swap_idx) ? perm[pivot] : perm[src_idx];
            end
            else
            begin
                perm_next[m] = perm[m];
            end
        end
    end

endmodule

### rtl/min_cost_permutation_search_unit.sv
`timescale 1ns / 1ps

// Brute-force assignment search. Matrix entries are taken one per cycle in
// row-major order into a 64-entry cost RAM. The entry flagged last_entry
// starts the search, during which no input is taken: every permutation of
// the n active columns is visited in lexicographic order, and its total is
// built by one shared saturating accumulator fed by the single RAM read port,
// one row per cycle plus a final step to close, compare and step the
// permutation. Results follow at one per cycle unless stalled: n results
// for a found assignment, or a single not-found result carrying the
// start bound.
module min_cost_permutation_search_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  mcps_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output mcps_pkg::out_item_t                 out_data,
    input  logic                                cfg_write,
    input  logic [mcps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mcps_pkg::DATA_W-1:0]         cfg_data
);

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_TAIL = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;

    logic [2:0]                        state_reg, state_next;
    logic [mcps_pkg::SIZE_W-1:0]       size_reg;
    logic [mcps_pkg::SUM_W-1:0]        bound_reg;
    logic [mcps_pkg::ADDR_W-1:0]       load_count_reg, load_count_next;
    logic [mcps_pkg::SIZE_W-1:0]       n_reg, n_next;
    logic [mcps_pkg::IDX_W-1:0]        row_reg, row_next;
    logic [mcps_pkg::ADDR_W-1:0]       base_reg, base_next;
    logic [mcps_pkg::SUM_W-1:0]        acc_reg, acc_next;
    logic [mcps_pkg::SUM_W-1:0]        best_reg, best_next;
    logic                              have_best_reg, have_best_next;
    mcps_pkg::perm_t                   perm_reg, perm_next;
    mcps_pkg::perm_t                   best_perm_reg, best_perm_next;
    mcps_pkg::perm_t                   perm_step;
    mcps_pkg::perm_t                   identity;
    logic                              perm_more;
    logic                              in_xfer;
    logic                              out_xfer;
    logic                              last_row;
    logic                              emit_last;
    logic [mcps_pkg::SIZE_W-1:0]       n_active;
    logic [mcps_pkg::ADDR_W-1:0]       rd_addr;
    logic [mcps_pkg::COST_W-1:0]       rd_cost;
    logic [mcps_pkg::SUM_W:0]          sum_ext;
    logic [mcps_pkg::SUM_W-1:0]        sum_sat;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;
    assign in_stall = (state_reg != ST_LOAD);
    assign out_valid = (state_reg == ST_EMIT);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= mcps_pkg::SIZE_RESET;
            bound_reg <= mcps_pkg::BOUND_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mcps_pkg::REG_SIZE_IN_USE: size_reg  <= cfg_data[mcps_pkg::SIZE_W-1:0];
                mcps_pkg::REG_START_BOUND: bound_reg <= cfg_data[mcps_pkg::SUM_W-1:0];
                default:                   ;
            endcase
        end
    end

    // Clamp the configured size into one to MAX_N.
    always_comb
    begin
        if (size_reg == '0)
        begin
            n_active = mcps_pkg::SIZE_W'(1);
        end
        else if (size_reg > mcps_pkg::SIZE_W'(mcps_pkg::MAX_N))
        begin
            n_active = mcps_pkg::SIZE_W'(mcps_pkg::MAX_N);
        end
        else
        begin
            n_active = size_reg;
        end
    end

    always_comb
    begin
        for (int m = 0; m < mcps_pkg::MAX_N; m++)
        begin
            identity[m] = mcps_pkg::IDX_W'(m);
        end
    end

    // Cost store: written while loading, read one row per cycle while searching.
    assign rd_addr = base_reg + mcps_pkg::ADDR_W'(perm_reg[row_reg]);

    mcps_ram #(
        .WIDTH (mcps_pkg::COST_W),
        .DEPTH (mcps_pkg::DEPTH)
    ) u_cost_ram (
        .clk     (clk),
        .wr_en   (in_xfer),
        .wr_addr (load_count_reg),
        .wr_data (in_data.cost),
        .rd_addr (rd_addr),
        .rd_data (rd_cost)
    );

    // Lexicographic successor of the current permutation.
    mcps_perm_next u_perm_next (
        .perm      (perm_reg),
        .n         (n_reg),
        .perm_next (perm_step),
        .has_next  (perm_more)
    );

    // Shared saturating accumulator; read data belongs to the previous row.
    always_comb
    begin
        sum_ext = {1'b0, acc_reg} + (mcps_pkg::SUM_W + 1)'(rd_cost);
        sum_sat = sum_ext[mcps_pkg::SUM_W] ? '1 : sum_ext[mcps_pkg::SUM_W-1:0];
    end

    assign last_row  = ((mcps_pkg::SIZE_W'(row_reg) + mcps_pkg::SIZE_W'(1)) == n_reg);
    assign emit_last = !have_best_reg || last_row;

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        n_next          = n_reg;
        row_next        = row_reg;
        base_next       = base_reg;
        acc_next        = acc_reg;
        best_next       = best_reg;
        have_best_next  = have_best_reg;
        perm_next       = perm_reg;
        best_perm_next  = best_perm_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    load_count_next = load_count_reg + mcps_pkg::ADDR_W'(1);
                    if (in_data.last_entry)
                    begin
                        load_count_next = '0;
                        n_next          = n_active;
                        perm_next       = identity;
                        best_next       = bound_reg;
                        have_best_next  = 1'b0;
                        row_next        = '0;
                        base_next       = '0;
                        state_next      = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                acc_next  = (row_reg == '0) ? '0 : sum_sat;
                base_next = base_reg + mcps_pkg::ADDR_W'(n_reg);
                if (last_row)
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    row_next = row_reg + mcps_pkg::IDX_W'(1);
                end
            end
            ST_TAIL:
            begin
                // Close the total, keep it if strictly better, step the permutation.
                if (sum_sat < best_reg)
                begin
                    best_next      = sum_sat;
                    have_best_next = 1'b1;
                    best_perm_next = perm_reg;
                end
                row_next  = '0;
                base_next = '0;
                if (perm_more)
                begin
                    perm_next  = perm_step;
                    state_next = ST_SUM;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_xfer)
                begin
                    if (emit_last)
                    begin
                        row_next   = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        row_next = row_reg + mcps_pkg::IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            load_count_reg <= '0;
            n_reg          <= mcps_pkg::SIZE_RESET;
            row_reg        <= '0;
            base_reg       <= '0;
            acc_reg        <= '0;
            best_reg       <= mcps_pkg::BOUND_RESET;
            have_best_reg  <= 1'b0;
            perm_reg       <= identity;
            best_perm_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            n_reg          <= n_next;
            row_reg        <= row_next;
            base_reg       <= base_next;
            acc_reg        <= acc_next;
            best_reg       <= best_next;
            have_best_reg  <= have_best_next;
            perm_reg       <= perm_next;
            best_perm_reg  <= best_perm_next;
        end
    end

    // Result fields come straight from held registers, so they stay put while stalled.
    always_comb
    begin
        out_data.best_sum    = best_reg;
        out_data.found       = have_best_reg;
        out_data.last_result = emit_last;
        if (have_best_reg)
        begin
            out_data.row    = mcps_pkg::ROW_W'(row_reg);
            out_data.column = mcps_pkg::ROW_W'(best_perm_reg[row_reg]);
        end
        else
        begin
            out_data.row    = '0;
            out_data.column = '0;
        end
    end

endmodule

### tb/sv/mcps_assignment_checker.sv
`timescale 1ns / 1ps

module mcps_assignment_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  mcps_pkg::in_item_t              in_data,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  mcps_pkg::out_item_t             out_data,
    input  logic                            cfg_write,
    input  logic [mcps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcps_pkg::DATA_W-1:0]     cfg_data,
    output int                              fail_count,
    output int                              pending,
    output int                              rows_seen,
    output int                              misses_seen
);
    import mcps_pkg::*;

    // Shadow copy of the block: cost memory, write pointer and registers.
    bit [COST_W-1:0] cost_copy [DEPTH];
    bit [ADDR_W-1:0] load_ptr;
    bit [SIZE_W-1:0] size_copy;
    bit [SUM_W-1:0]  bound_copy;

    // Assignment rows predicted but not yet delivered, oldest first.
    out_item_t predicted_rows [$];

    // Walk all permutations in lexicographic order from the identity and keep
    // the first one whose total is strictly below the running minimum.
    function automatic void search_min_assignment();
        int unsigned     n;
        int unsigned     i;
        int unsigned     j;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     r;
        bit [IDX_W-1:0]  order [MAX_N];
        bit [IDX_W-1:0]  chosen [MAX_N];
        bit [IDX_W-1:0]  swap_tmp;
        longint unsigned acc;
        bit [SUM_W-1:0]  total;
        bit [SUM_W-1:0]  lowest;
        bit              found;
        bit              more;
        out_item_t       row_item;

        // A size of zero acts as one, anything above the maximum as the maximum.
        n = (size_copy == 0) ? 1 : ((size_copy > MAX_N) ? MAX_N : size_copy);
        for (i = 0; i < MAX_N; i++)
        begin
            order[i]  = IDX_W'(i);
            chosen[i] = '0;
        end
        lowest = bound_copy;
        found  = 1'b0;
        more   = 1'b1;

        while (more)
        begin
            acc = 0;
            for (r = 0; r < n; r++)
                acc += cost_copy[ADDR_W'(r * n + order[r])];
            total = (acc > 64'hFFFF_FFFF) ? '1 : acc[SUM_W-1:0];
            if (total < lowest)
            begin
                lowest = total;
                found  = 1'b1;
                chosen = order;
            end

            // Step to the next permutation; stop after the descending one.
            more = 1'b0;
            if (n >= 2)
            begin
                i = n - 1;
                while (i > 0 && order[i-1] >= order[i])
                    i--;
                if (i > 0)
                begin
                    j = n - 1;
                    while (order[j] <= order[i-1])
                        j--;
                    swap_tmp   = order[i-1];
                    order[i-1] = order[j];
                    order[j]   = swap_tmp;
                    lo = i;
                    hi = n - 1;
                    while (lo < hi)
                    begin
                        swap_tmp  = order[lo];
                        order[lo] = order[hi];
                        order[hi] = swap_tmp;
                        lo++;
                        hi--;
                    end
                    more = 1'b1;
                end
            end
        end

        // Nothing beat the bound: a single report carrying the bound itself.
        if (!found)
        begin
            row_item             = '0;
            row_item.best_sum    = lowest;
            row_item.last_result = 1'b1;
            predicted_rows.push_back(row_item);
        end
        else
        begin
            for (r = 0; r < n; r++)
            begin
                row_item.row         = ROW_W'(r);
                row_item.column      = ROW_W'(chosen[r]);
                row_item.best_sum    = lowest;
                row_item.found       = 1'b1;
                row_item.last_result = (r == n - 1);
                predicted_rows.push_back(row_item);
            end
        end
    endfunction

    // Store one matrix entry; the flagged last entry launches the search.
    function automatic void take_entry(input in_item_t entry);
        cost_copy[load_ptr] = entry.cost;
        load_ptr = load_ptr + 1'b1;
        if (entry.last_entry)
        begin
            load_ptr = '0;
            search_min_assignment();
        end
    endfunction

    // Compare one delivered row with the oldest prediction.
    function automatic void check_row(input out_item_t got);
        out_item_t want;

        if (predicted_rows.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("Unexpected result row %0d column %0d sum %h found %0b last %0b",
                         got.row, got.column, got.best_sum, got.found, got.last_result);
        end
        else
        begin
            want = predicted_rows.pop_front();
            if (want.found)
                rows_seen++;
            else
                misses_seen++;
            if (got.row !== want.row || got.column !== want.column ||
                got.best_sum !== want.best_sum || got.found !== want.found ||
                got.last_result !== want.last_result)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("Result differs: expected row %0d column %0d sum %h found %0b last %0b",
                             want.row, want.column, want.best_sum, want.found,
                             want.last_result);
                    $display("                got row %0d column %0d sum %h found %0b last %0b",
                             got.row, got.column, got.best_sum, got.found,
                             got.last_result);
                end
            end
        end
    endfunction

    // Everything is sampled at the rising edge, the same edge the block uses.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            size_copy   = SIZE_RESET;
            bound_copy  = BOUND_RESET;
            load_ptr    = '0;
            fail_count  = 0;
            rows_seen   = 0;
            misses_seen = 0;
            predicted_rows.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
                check_row(out_data);
            if (cfg_write)
            begin
                if (cfg_index == REG_SIZE_IN_USE)
                    size_copy = cfg_data[SIZE_W-1:0];
                else if (cfg_index == REG_START_BOUND)
                    bound_copy = cfg_data[SUM_W-1:0];
            end
            if (in_valid && !in_stall)
                take_entry(in_data);
        end
        pending = predicted_rows.size();
    end

endmodule

### tb/sv/min_cost_permutation_search_unit_tb.sv
`timescale 1ns / 1ps

module min_cost_permutation_search_unit_tb;
    import mcps_pkg::*;

    // Two full 8x8 searches dominate the run time; everything else is small.
    localparam int CLOCK_LIMIT    = 4_000_000;
    localparam int SETTLE         = 16;
    localparam int RANDOM_ENTRIES = 300;
    localparam int HOLD_CYCLES    = 600;

    typedef enum {WIDE_COSTS, NARROW_COSTS, CORNER_COSTS, TIED_COSTS} cost_style_e;
    typedef enum {FULL_LOAD, SHORT_LOAD, LONG_LOAD} load_kind_e;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [DATA_W-1:0]     cfg_data  = '0;

    int fail_count;
    int pending;
    int rows_seen;
    int misses_seen;
    int cycle_count    = 0;
    int entries_sent   = 0;
    int searches_sent  = 0;
    int random_entries = 0;
    bit hold_wanted    = 1'b0;
    logic [SIZE_W-1:0] size_code = SIZE_RESET;

    min_cost_permutation_search_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mcps_assignment_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .rows_seen   (rows_seen),
        .misses_seen (misses_seen)
    );

    always #2 clk = ~clk;

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CLOCK_LIMIT)
        begin
            $display("min_cost_permutation_search_unit: mismatch");
            $finish;
        end
    end

    // Result side: alternating free and stalled stretches, plus one long
    // hold-off on request so that the block backs up into its input.
    initial
    begin : result_sink
        int seg_left;
        int hold_left;
        int pick;
        bit stalling;
        bit hold_taken;

        seg_left   = 0;
        hold_left  = 0;
        stalling   = 1'b0;
        hold_taken = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_wanted && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    stalling = !stalling;
                    pick     = $urandom_range(0, 99);
                    if (stalling)
                        seg_left = (pick < 70) ? $urandom_range(1, 2) :
                                   (pick < 95) ? $urandom_range(3, 8) : $urandom_range(20, 60);
                    else
                        seg_left = (pick < 70) ? $urandom_range(1, 6) :
                                   (pick < 90) ? $urandom_range(7, 30) : $urandom_range(50, 200);
                end
                seg_left--;
                out_stall <= stalling;
            end
        end
    end

    function automatic int pick_gap();
        int pick;

        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COST_W-1:0] pick_cost(input cost_style_e style);
        case (style)
            WIDE_COSTS:   return COST_W'($urandom_range(0, 24'hFF_FFFF));
            NARROW_COSTS: return COST_W'($urandom_range(0, 255));
            CORNER_COSTS:
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return '1;
                    2:       return 24'h80_0000;
                    default: return 24'h00_0001;
                endcase
            default:      return COST_W'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic int active_n(input logic [SIZE_W-1:0] code);
        return (code == 0) ? 1 : ((code > MAX_N) ? MAX_N : int'(code));
    endfunction

    // Bounds range from never-beaten to always-beaten, with mixed cases between.
    function automatic logic [SUM_W-1:0] pick_bound(input int n);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            3:       return $urandom_range(0, n * 1024);
            4:       return $urandom_range(0, n * 24'hFF_FFFF);
            default: return BOUND_RESET;
        endcase
    endfunction

    // Small sizes keep searches short; six is the largest used at random.
    function automatic logic [SIZE_W-1:0] pick_size();
        int pick;

        pick = $urandom_range(0, 99);
        if (pick < 4)
            return '0;
        if (pick < 30)
            return SIZE_W'($urandom_range(1, 2));
        if (pick < 75)
            return 4'd3;
        if (pick < 93)
            return 4'd4;
        if (pick < 99)
            return 4'd5;
        return 4'd6;
    endfunction

    // Offer one matrix entry and hold it until the block takes the transfer.
    task automatic offer_entry(input logic [COST_W-1:0] cost, input bit last, input bit no_gaps);
        int gap;

        gap = no_gaps ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{cost: cost, last_entry: last};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        entries_sent++;
    endtask

    task automatic load_matrix(input int count, input cost_style_e style, input bit no_gaps);
        for (int k = 0; k < count; k++)
            offer_entry(pick_cost(style), k == count - 1, no_gaps);
        searches_sent++;
    endtask

    task automatic send_constant(input int count, input logic [COST_W-1:0] value);
        for (int k = 0; k < count; k++)
            offer_entry(value, k == count - 1, 1'b0);
        searches_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Only the low bits carry the size; the rest is sometimes filled at random.
    task automatic set_size(input logic [SIZE_W-1:0] code);
        logic [DATA_W-1:0] word;

        word = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom) : '0;
        word[SIZE_W-1:0] = code;
        write_reg(REG_SIZE_IN_USE, word);
        size_code = code;
    endtask

    // Stop offering and wait until every predicted row has been delivered.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int n;
        int count;
        bit first;
        load_kind_e kind;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // A full 8x8 load under the reset settings writes every memory entry,
        // so later short loads may lean on what is left over.
        load_matrix(DEPTH, NARROW_COSTS, 1'b0);
        drain();

        // Size zero behaves as one; the largest cost against an open bound.
        set_size('0);
        write_reg(REG_START_BOUND, '1);
        send_constant(1, '1);
        drain();

        // A zero total never beats a zero bound.
        set_size(4'd1);
        write_reg(REG_START_BOUND, '0);
        send_constant(1, '0);
        drain();

        // All totals tie: the identity, found first, must win.
        set_size(4'd2);
        write_reg(REG_START_BOUND, 32'd1);
        send_constant(4, '0);
        drain();
        write_reg(REG_START_BOUND, '1);
        send_constant(4, '1);
        drain();

        // An oversized size acts as eight; one new entry, the rest left over.
        set_size(4'd15);
        send_constant(1, 24'h12_3456);
        drain();

        // Cheapest on the anti-diagonal, the last permutation visited.
        set_size(4'd4);
        write_reg(REG_START_BOUND, 32'h0040_0000);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                offer_entry((c == 3 - r) ? 24'd1 : 24'h10_0000, r == 3 && c == 3, 1'b0);
        searches_sent++;
        drain();

        // Back-to-back small matrices while the result side holds off.
        set_size(4'd2);
        write_reg(REG_START_BOUND, '1);
        hold_wanted = 1'b1;
        repeat (4) load_matrix(4, WIDE_COSTS, 1'b1);
        drain();

        // Random matrices; the first one overruns the 64-entry pointer.
        first = 1'b1;
        while (random_entries < RANDOM_ENTRIES)
        begin
            if (!first && $urandom_range(0, 9) < 3)
            begin
                drain();
                if ($urandom_range(0, 1) == 1)
                    set_size(pick_size());
                write_reg(REG_START_BOUND, pick_bound(active_n(size_code)));
            end
            n = active_n(size_code);
            case ($urandom_range(0, 99)) inside
                [0:74]:  kind = FULL_LOAD;
                [75:87]: kind = SHORT_LOAD;
                default: kind = LONG_LOAD;
            endcase
            if (first)
                count = 66;
            else if (kind == SHORT_LOAD && n > 1)
                count = $urandom_range(1, n * n - 1);
            else if (kind == LONG_LOAD)
                count = n * n + $urandom_range(1, 70);
            else
                count = n * n;
            load_matrix(count, cost_style_e'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
            random_entries += count;
            first = 1'b0;
        end
        drain();
        repeat (40) @(negedge clk);

        $display("Sent %0d matrix entries over %0d searches, sizes 0 to 15 and bounds 0 to max.",
                 entries_sent, searches_sent);
        $display("Checked %0d assignment rows and %0d not-found reports.",
                 rows_seen, misses_seen);
        if (fail_count == 0 && pending == 0)
            $display("min_cost_permutation_search_unit: match");
        else
            $display("min_cost_permutation_search_unit: mismatch");
        $finish;
    end

endmodule
